// ----- rtl/ame_pkg.sv -----
// Package with shared types, constants and command codes of the accumulator machine execute unit.
package ame_pkg;

    localparam int NUM_REGS   = 32;
    localparam int REG_AW     = 5;
    localparam int LINE_W     = 10;
    localparam int ADDR_W     = 20;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_DIV  = 4'd3,
        CMD_REM  = 4'd4,
        CMD_ADDI = 4'd5,
        CMD_SUBI = 4'd6,
        CMD_STI  = 4'd7,
        CMD_STO  = 4'd8,
        CMD_STOM = 4'd9,
        CMD_DSP  = 4'd10,
        CMD_BEQ  = 4'd11,
        CMD_BLT  = 4'd12,
        CMD_JUMP = 4'd13,
        CMD_NOP0 = 4'd14,
        CMD_NOP1 = 4'd15
    } t_cmd;

    // Request to the shared divider and its answer.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [63:0] remainder;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

// ----- rtl/ame_div.sv -----
// Restoring unsigned divider, 64 by 64 bits, one quotient bit per cycle.
module ame_div
    import ame_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [63:0] r_quo;
    logic [64:0] r_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_shift;
    logic [64:0] w_diff;

    assign w_shift = {r_rem[63:0], r_quo[63]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quo  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_diff[64]) begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[63:0];

endmodule

// ----- rtl/accumulator_machine_execute.sv -----
// Top level of the accumulator machine execute unit.
//
// One decoded instruction enters per input transaction on i_valid/o_ready and
// produces exactly one result transaction on o_valid/i_ready. Instructions are
// executed one at a time. The register file is a synchronous memory with one
// registered read port; the two operands are read one after the other.
// MUL goes through an extra multiplier register (S_MUL). DIV and REM with a
// nonzero divisor (for REM, its integer part) wait in S_DIV for the
// 64-step restoring divider, which produces one quotient bit per cycle.
// A zero divisor skips the divider.
// After the result has been taken, o_ready rises again the next cycle.
// At reset the accumulator, line counter and store pointer clear, and a
// clearing pass writes zero to all 32 register entries, one per cycle, so
// o_ready stays low after reset is released until the pass is done.
// If the receiver stalls, the result register holds its value and no new
// instruction is taken until the result transaction completes.
module accumulator_machine_execute
    import ame_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_command,
    input  logic [4:0]         i_reg_first,
    input  logic [4:0]         i_reg_second,
    input  logic [7:0]         i_small_constant,
    input  logic signed [31:0] i_load_value,
    input  logic [10:0]        i_target_line,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_accumulator,
    output logic [9:0]         o_next_line,
    output logic               o_store_valid,
    output logic [19:0]        o_store_address,
    output logic [15:0]        o_store_data,
    output logic               o_divide_error
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RDB   = 8'b0000_0100,
        S_WAITB = 8'b0000_1000,
        S_EXEC  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;

    // Register file memory.
    logic signed [31:0] r_mem [NUM_REGS];
    logic signed [31:0] r_rdata;
    logic [REG_AW-1:0]  w_raddr;
    logic               w_we;
    logic [REG_AW-1:0]  w_waddr;
    logic signed [31:0] w_wdata;

    logic [REG_AW:0]    r_clr;
    t_cmd               r_cmd;
    logic [4:0]         r_r1;
    logic [4:0]         r_r2;
    logic [7:0]         r_k;
    logic signed [31:0] r_load;
    logic [10:0]        r_tgt;
    logic signed [31:0] r_a;
    logic signed [31:0] r_acc;
    logic [LINE_W-1:0]  r_line;
    logic [ADDR_W-1:0]  r_sp;
    logic signed [63:0] r_prod;
    logic               r_neg;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    logic signed [31:0] w_b;
    logic signed [31:0] w_ia;
    logic signed [31:0] w_ib;
    logic signed [63:0] w_num;
    logic signed [63:0] w_den;
    logic signed [63:0] w_q;

    assign w_b  = r_rdata;
    assign w_ia = r_a / 32'sd65536;
    assign w_ib = w_b / 32'sd65536;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign w_raddr = (r_state == S_IDLE) ? i_reg_first : r_r2;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_r1;
        w_wdata = '0;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr[REG_AW-1:0];
        end else if (r_state == S_EXEC) begin
            unique case (r_cmd)
                CMD_ADDI: begin
                    w_we    = 1'b1;
                    w_wdata = sat32(66'(r_a) + 66'({r_k, 16'h0}));
                end
                CMD_SUBI: begin
                    w_we    = 1'b1;
                    w_wdata = sat32(66'(r_a) - 66'({r_k, 16'h0}));
                end
                CMD_STI: begin
                    w_we    = 1'b1;
                    w_wdata = r_load;
                end
                CMD_STO: begin
                    w_we    = 1'b1;
                    w_wdata = r_acc;
                end
                default: w_we = 1'b0;
            endcase
        end
    end

    // Divider operands: magnitudes, the sign is applied afterwards.
    always_comb begin
        if (r_cmd == CMD_DIV) begin
            w_num = 64'(r_a) <<< 16;
            w_den = 64'(w_b);
        end else begin
            w_num = 64'(w_ia);
            w_den = 64'(w_ib);
        end
    end

    assign w_dreq.start    = (r_state == S_EXEC) &&
                             (((r_cmd == CMD_DIV) && (w_b != 0)) ||
                              ((r_cmd == CMD_REM) && (w_ib != 0)));
    assign w_dreq.dividend = w_num[63] ? -w_num : w_num;
    assign w_dreq.divisor  = w_den[63] ? -w_den : w_den;

    ame_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    assign w_q = (r_cmd == CMD_DIV) ?
                 (r_neg ? -$signed(w_drsp.quotient) : $signed(w_drsp.quotient)) :
                 (r_neg ? -$signed(w_drsp.remainder) : $signed(w_drsp.remainder));

    logic [10:0] w_tm1;
    assign w_tm1 = r_tgt - 11'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_acc          <= '0;
            r_line         <= '0;
            r_sp           <= '0;
            o_valid        <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (REG_AW+1)'(NUM_REGS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= t_cmd'(i_command);
                        r_r1    <= i_reg_first;
                        r_r2    <= i_reg_second;
                        r_k     <= i_small_constant;
                        r_load  <= i_load_value;
                        r_tgt   <= i_target_line;
                        r_state <= S_RDB;
                    end
                end
                S_RDB: begin
                    r_a     <= r_rdata;
                    r_state <= S_WAITB;
                end
                S_WAITB: r_state <= S_EXEC;
                S_EXEC: begin
                    o_store_valid   <= 1'b0;
                    o_store_address <= '0;
                    o_store_data    <= '0;
                    o_divide_error  <= 1'b0;
                    r_state         <= S_OUT;
                    if ((r_cmd == CMD_BEQ && r_a == w_b) ||
                        (r_cmd == CMD_BLT && r_a < w_b) || r_cmd == CMD_JUMP) begin
                        r_line <= w_tm1[LINE_W-1:0];
                    end else begin
                        r_line <= r_line + 1'b1;
                    end
                    unique case (r_cmd)
                        CMD_ADD: r_acc <= sat32(66'(r_a) + 66'(w_b));
                        CMD_SUB: r_acc <= sat32(66'(r_a) - 66'(w_b));
                        CMD_MUL: begin
                            r_prod  <= r_a * w_b;
                            r_state <= S_MUL;
                        end
                        CMD_DIV: begin
                            r_neg <= r_a[31] ^ w_b[31];
                            if (w_b == 0) begin
                                o_divide_error <= 1'b1;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        CMD_REM: begin
                            r_neg <= w_ia[31];
                            if (w_ib == 0) begin
                                o_divide_error <= 1'b1;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        CMD_ADDI: r_acc <= w_wdata;
                        CMD_SUBI: r_acc <= w_wdata;
                        CMD_STOM: begin
                            o_store_valid   <= 1'b1;
                            o_store_address <= r_sp;
                            o_store_data    <= 16'(r_acc / 32'sd65536);
                            r_sp            <= r_sp + 1'b1;
                        end
                        default: r_acc <= r_acc;
                    endcase
                end
                S_MUL: begin
                    // Arithmetic shift floors toward minus infinity.
                    r_acc   <= sat32(66'(r_prod >>> 16));
                    r_state <= S_OUT;
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        if (r_cmd == CMD_DIV) begin
                            r_acc <= sat32(66'(w_q));
                        end else begin
                            r_acc <= 32'(w_q) <<< 16;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    if (o_valid && i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_accumulator = r_acc;
    assign o_next_line   = r_line;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while result pending");
    a_div_only_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drsp.done |-> (r_state == S_DIV)) else $error("divider done out of place");
    a_sp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_store_valid) |-> (r_sp == o_store_address + 1'b1))
        else $error("store pointer out of step");
`endif

endmodule

// ----- test/accumulator_machine_execute_tb.sv -----
// Self-checking testbench for the accumulator machine execute unit.
`timescale 1ns / 100ps

module accumulator_machine_execute_tb
    import ame_pkg::*;
();

    typedef struct packed {
        logic [3:0]         command;
        logic [4:0]         reg_first;
        logic [4:0]         reg_second;
        logic [7:0]         small_constant;
        logic signed [31:0] load_value;
        logic [10:0]        target_line;
    } t_instr;

    typedef struct packed {
        logic signed [31:0] accumulator;
        logic [9:0]         next_line;
        logic               store_valid;
        logic [19:0]        store_address;
        logic [15:0]        store_data;
        logic               divide_error;
    } t_outcome;

    localparam int STALL_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [3:0]         i_command;
    logic [4:0]         i_reg_first;
    logic [4:0]         i_reg_second;
    logic [7:0]         i_small_constant;
    logic signed [31:0] i_load_value;
    logic [10:0]        i_target_line;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_accumulator;
    logic [9:0]         o_next_line;
    logic               o_store_valid;
    logic [19:0]        o_store_address;
    logic [15:0]        o_store_data;
    logic               o_divide_error;

    accumulator_machine_execute uut (.*);

    // Predictor state, a private copy of the machine's architectural state.
    logic signed [31:0] model_regs [NUM_REGS];
    logic signed [31:0] model_acc;
    logic [LINE_W-1:0]  model_line;
    logic [ADDR_W-1:0]  model_store_ptr;

    t_instr   pending_instrs [$];
    t_outcome expected_outcomes [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  recv_holdoff;
    int  fail_count;
    int  quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -66'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // Executes one instruction on the model state and returns the result
    // the block should report for it.
    function automatic t_outcome execute_instr(input t_instr t);
        t_outcome o;
        logic signed [63:0] a, b, p, ia, ib, k;
        logic signed [31:0] v;
        bit branch;
        o = '0;
        branch = 1'b0;
        a = (t.reg_first < NUM_REGS) ? 64'(model_regs[t.reg_first]) : 64'sd0;
        b = (t.reg_second < NUM_REGS) ? 64'(model_regs[t.reg_second]) : 64'sd0;
        k = 64'(t.small_constant) * 65536;
        case (t_cmd'(t.command))
            CMD_ADD: model_acc = clamp32(66'(a + b));
            CMD_SUB: model_acc = clamp32(66'(a - b));
            CMD_MUL: begin
                // The product shifted right rounds toward minus infinity.
                p = a * b;
                model_acc = clamp32(66'(p >>> 16));
            end
            CMD_DIV: begin
                if (b == 0) o.divide_error = 1'b1;
                else model_acc = clamp32(66'((a * 65536) / b));
            end
            CMD_REM: begin
                ia = a / 65536;
                ib = b / 65536;
                if (ib == 0) o.divide_error = 1'b1;
                else model_acc = 32'((ia % ib) * 65536);
            end
            CMD_ADDI, CMD_SUBI: begin
                v = clamp32(66'((t.command == CMD_ADDI) ? a + k : a - k));
                if (t.reg_first < NUM_REGS) model_regs[t.reg_first] = v;
                model_acc = v;
            end
            CMD_STI: if (t.reg_first < NUM_REGS) model_regs[t.reg_first] = t.load_value;
            CMD_STO: if (t.reg_first < NUM_REGS) model_regs[t.reg_first] = model_acc;
            CMD_STOM: begin
                o.store_valid = 1'b1;
                o.store_address = model_store_ptr;
                // Integer part truncates toward zero.
                o.store_data = 16'(64'(model_acc) / 65536);
                model_store_ptr = model_store_ptr + 1'b1;
            end
            CMD_BEQ: branch = (a == b);
            CMD_BLT: branch = (a < b);
            CMD_JUMP: branch = 1'b1;
            default: ;
        endcase
        // A ten-bit line counter wraps modulo 1024 by itself.
        if (branch) model_line = LINE_W'(t.target_line - 11'd1);
        else model_line = model_line + 1'b1;
        o.accumulator = model_acc;
        o.next_line = model_line;
        return o;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'($urandom_range(0, 8)) <<< 16;
            3: return -(32'($urandom_range(0, 8)) <<< 16);
            4: return 32'(int'($urandom_range(0, 400000)) - 200000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_instr random_instr();
        t_instr t;
        t.command = 4'($urandom_range(0, 15));
        // Mostly small register indexes so operands are reused and meaningful.
        t.reg_first = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
        t.reg_second = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
        t.small_constant = 8'($urandom);
        t.load_value = pick_value();
        t.target_line = 11'($urandom);
        return t;
    endfunction

    function automatic t_instr make_instr(input t_cmd c, input int r1, input int r2,
                                          input int k, input logic signed [31:0] lv,
                                          input int tl);
        t_instr t;
        t.command = c;
        t.reg_first = 5'(r1);
        t.reg_second = 5'(r2);
        t.small_constant = 8'(k);
        t.load_value = lv;
        t.target_line = 11'(tl);
        return t;
    endfunction

    // Driver: offers the oldest pending instruction and keeps it steady
    // until the transaction completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_instrs.size() > 0 && ($urandom_range(0, 99) >= send_idle_pct)) begin
                t_instr t;
                t = pending_instrs.pop_front();
                i_valid          <= 1'b1;
                i_command        <= t.command;
                i_reg_first      <= t.reg_first;
                i_reg_second     <= t.reg_second;
                i_small_constant <= t.small_constant;
                i_load_value     <= t.load_value;
                i_target_line    <= t.target_line;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Prediction happens when the instruction transaction completes.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_outcomes.push_back(execute_instr({i_command, i_reg_first, i_reg_second,
                i_small_constant, i_load_value, i_target_line}));
        end
    end

    // Receiver: random back-pressure plus an optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (recv_holdoff > 0) begin
            recv_holdoff <= recv_holdoff - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: compares each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outcomes.size() == 0) begin
                $error("Result transaction with no instruction outstanding");
                fail_count = fail_count + 1;
            end else begin
                t_outcome e;
                e = expected_outcomes.pop_front();
                if (o_accumulator !== e.accumulator) begin
                    $error("accumulator expected %0d actual %0d", e.accumulator, o_accumulator);
                    fail_count = fail_count + 1;
                end
                if (o_next_line !== e.next_line) begin
                    $error("next_line expected %0d actual %0d", e.next_line, o_next_line);
                    fail_count = fail_count + 1;
                end
                if (o_store_valid !== e.store_valid) begin
                    $error("store_valid expected %0d actual %0d", e.store_valid, o_store_valid);
                    fail_count = fail_count + 1;
                end
                if (o_store_address !== e.store_address) begin
                    $error("store_address expected %0d actual %0d",
                           e.store_address, o_store_address);
                    fail_count = fail_count + 1;
                end
                if (o_store_data !== e.store_data) begin
                    $error("store_data expected %0d actual %0d", e.store_data, o_store_data);
                    fail_count = fail_count + 1;
                end
                if (o_divide_error !== e.divide_error) begin
                    $error("divide_error expected %0d actual %0d",
                           e.divide_error, o_divide_error);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Watchdog: counts cycles without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_instrs.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_outcomes.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_command = '0;
        i_reg_first = '0;
        i_reg_second = '0;
        i_small_constant = '0;
        i_load_value = '0;
        i_target_line = '0;
        fail_count = 0;
        quiet_cycles = 0;
        recv_holdoff = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (model_regs[i]) model_regs[i] = '0;
        model_acc = '0;
        model_line = '0;
        model_store_ptr = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: field extremes, every command and the special cases.
        pending_instrs.push_back(make_instr(CMD_STI, 1, 0, 0, 32'sh7FFFFFFF, 1));
        pending_instrs.push_back(make_instr(CMD_STI, 2, 0, 0, 32'sh80000000, 1));
        pending_instrs.push_back(make_instr(CMD_STI, 3, 0, 0, -32'sh18000, 1));
        pending_instrs.push_back(make_instr(CMD_STI, 31, 0, 0, 32'sh00030000, 1));
        pending_instrs.push_back(make_instr(CMD_ADD, 1, 1, 0, 0, 1));     // saturates high
        pending_instrs.push_back(make_instr(CMD_SUB, 2, 1, 0, 0, 1));     // saturates low
        pending_instrs.push_back(make_instr(CMD_MUL, 3, 31, 0, 0, 1));
        pending_instrs.push_back(make_instr(CMD_MUL, 2, 2, 0, 0, 1));
        pending_instrs.push_back(make_instr(CMD_DIV, 1, 3, 0, 0, 1));
        pending_instrs.push_back(make_instr(CMD_DIV, 1, 4, 0, 0, 1));     // zero divisor
        pending_instrs.push_back(make_instr(CMD_REM, 2, 31, 0, 0, 1));
        pending_instrs.push_back(make_instr(CMD_REM, 1, 3, 0, 0, 1));     // divisor truncates to -1
        pending_instrs.push_back(make_instr(CMD_STI, 5, 0, 0, 32'sh00008000, 1));
        pending_instrs.push_back(make_instr(CMD_REM, 1, 5, 0, 0, 1));     // divisor truncates to 0
        pending_instrs.push_back(make_instr(CMD_ADDI, 1, 0, 255, 0, 1));
        pending_instrs.push_back(make_instr(CMD_SUBI, 2, 0, 255, 0, 1));
        pending_instrs.push_back(make_instr(CMD_ADDI, 31, 0, 0, 0, 1));
        pending_instrs.push_back(make_instr(CMD_STO, 6, 0, 0, 0, 1));
        pending_instrs.push_back(make_instr(CMD_STOM, 0, 0, 0, 0, 1));
        pending_instrs.push_back(make_instr(CMD_DSP, 0, 0, 0, 0, 1));
        pending_instrs.push_back(make_instr(CMD_BEQ, 0, 4, 0, 0, 0));     // target wraps
        pending_instrs.push_back(make_instr(CMD_BLT, 2, 1, 0, 0, 2047));
        pending_instrs.push_back(make_instr(CMD_JUMP, 0, 0, 0, 0, 1024));
        pending_instrs.push_back(make_instr(CMD_NOP0, 0, 0, 0, 0, 1));
        pending_instrs.push_back(make_instr(CMD_NOP1, 0, 0, 0, 0, 1));
        drain();

        // Random part in three idling phases.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 66 : 0;
            recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 32 : 0;
            for (int n = 0; n < 375; n++) pending_instrs.push_back(random_instr());
            if (ph == 2) recv_holdoff <= 400; // long stall while the sender keeps offering
            drain();
        end
        repeat (100) @(posedge i_clk);

        if (fail_count == 0 && expected_outcomes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
